// ===== design/uf_mst_pkg.sv =====
// Package for the union-find spanning tree builder.
// Field widths, the count limit and the controller state type.
// No dependencies.
`default_nettype none
package uf_mst_pkg;

  localparam int NODE_ID_W = 10;
  localparam int LEN_W     = 20;
  localparam int CNT_W     = 10;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK_A,
    ST_WALK_B,
    ST_FINISH
  } state_t;

endpackage
`default_nettype wire

// ===== design/uf_mst_if.sv =====
// Valid/ready channel interfaces: edge words in, result words out.
// Depends on uf_mst_pkg for field widths.
`default_nettype none
interface uf_edge_if;
  import uf_mst_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [NODE_ID_W-1:0] node_a;
  logic [NODE_ID_W-1:0] node_b;
  logic [LEN_W-1:0]     edge_length;

  modport source (output valid, output node_a, output node_b, output edge_length,
                  input ready);
  modport sink   (input valid, input node_a, input node_b, input edge_length,
                  output ready);
endinterface

interface uf_result_if;
  import uf_mst_pkg::*;
  logic             valid;
  logic             ready;
  logic             accepted;
  logic [LEN_W-1:0] largest_length;
  logic [CNT_W-1:0] tree_edge_count;

  modport source (output valid, output accepted, output largest_length,
                  output tree_edge_count, input ready);
  modport sink   (input valid, input accepted, input largest_length,
                  input tree_edge_count, output ready);
endinterface
`default_nettype wire

// ===== design/uf_mst_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module uf_mst_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== design/union_find_spanning_tree_builder_top.sv =====
// Union-find spanning tree builder: Kruskal back end, top level.
// Depends on uf_mst_pkg, uf_edge_if / uf_result_if and uf_mst_ram.
//
// Takes one edge word at a time and returns one result word per edge. After
// reset the parent RAM is swept so every node points to itself; no edge is
// taken during the sweep. An edge then walks the parent links from node_a
// to its root and then from node_b to its root; the root walk reads the
// single parent RAM port once per link. An edge with an endpoint at or above
// MAX_NODES skips both walks and leaves the parent links, the largest length
// and the count alone. A finished result sits in the output register while
// the next edge is taken.
`default_nettype none
module union_find_spanning_tree_builder_top #(
  parameter int MAX_NODES = 1024
) (
  input wire logic  clk,
  input wire logic  rst_n,
  uf_edge_if.sink   in_ch,
  uf_result_if.source out_ch
);
  import uf_mst_pkg::*;

  localparam int NW    = $clog2(MAX_NODES);
  localparam int EXT_W = (NW > NODE_ID_W) ? NW : NODE_ID_W;
  localparam logic [NW-1:0] LAST_NODE = NW'(MAX_NODES - 1);

  state_t state_r, state_nxt;

  logic [NW-1:0]    clr_cnt_r;
  logic [NW-1:0]    cur_r;
  logic [NW-1:0]    root_a_r;
  logic [NW-1:0]    node_b_r;
  logic [LEN_W-1:0] len_r;
  logic             acc_r;
  logic [LEN_W-1:0] max_len_r;
  logic [CNT_W-1:0] count_r;

  logic             out_valid_r;
  logic             out_acc_r;
  logic [LEN_W-1:0] out_len_r;
  logic [CNT_W-1:0] out_cnt_r;

  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [NW-1:0] ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [NW-1:0] ram_rdata;

  logic [EXT_W-1:0] a_ext, b_ext;
  logic [NW-1:0]    a_idx, b_idx;
  logic             in_range;
  logic             in_accept;
  logic             at_root;
  logic             out_free;

  assign a_ext    = EXT_W'(in_ch.node_a);
  assign b_ext    = EXT_W'(in_ch.node_b);
  assign a_idx    = a_ext[NW-1:0];
  assign b_idx    = b_ext[NW-1:0];
  assign in_range = (32'(in_ch.node_a) < 32'(MAX_NODES)) &&
                    (32'(in_ch.node_b) < 32'(MAX_NODES));
  assign in_accept = in_ch.valid && in_ch.ready;
  assign at_root   = (ram_rdata == cur_r);
  assign out_free  = !out_valid_r || out_ch.ready;

  uf_mst_ram #(
    .WIDTH (NW),
    .DEPTH (MAX_NODES)
  ) u_parent (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_cnt_r == LAST_NODE) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_accept) state_nxt = in_range ? ST_WALK_A : ST_FINISH;
      end
      ST_WALK_A: begin
        if (at_root) state_nxt = ST_WALK_B;
      end
      ST_WALK_B: begin
        if (at_root) state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_CLEAR;
    endcase
  end

  // RAM control and input ready
  always_comb begin
    ram_we      = 1'b0;
    ram_waddr   = clr_cnt_r;
    ram_wdata   = clr_cnt_r;
    ram_raddr   = ram_rdata;
    in_ch.ready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        ram_we = 1'b1;
      end
      ST_IDLE: begin
        in_ch.ready = 1'b1;
        ram_raddr   = a_idx;
      end
      ST_WALK_A: begin
        // root of a found: start the walk from b
        ram_raddr = at_root ? node_b_r : ram_rdata;
      end
      ST_WALK_B: begin
        // link root of b under root of a when the sets differ
        if (at_root && (cur_r != root_a_r)) begin
          ram_we    = 1'b1;
          ram_waddr = cur_r;
          ram_wdata = root_a_r;
        end
      end
      ST_FINISH: begin
        ram_raddr = cur_r;
      end
      default: begin
        ram_raddr = cur_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_cnt_r   <= '0;
      max_len_r   <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) clr_cnt_r <= clr_cnt_r + 1'b1;

      if (state_r == ST_WALK_B && at_root && (cur_r != root_a_r)) begin
        if (len_r > max_len_r) max_len_r <= len_r;
        if (count_r != CNT_MAX) count_r <= count_r + 1'b1;
      end

      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      if (state_r == ST_FINISH && out_free) out_valid_r <= 1'b1;
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          cur_r    <= a_idx;
          node_b_r <= b_idx;
          len_r    <= in_ch.edge_length;
          acc_r    <= 1'b0;
        end
      end
      ST_WALK_A: begin
        if (at_root) begin
          root_a_r <= cur_r;
          cur_r    <= node_b_r;
        end else begin
          cur_r <= ram_rdata;
        end
      end
      ST_WALK_B: begin
        if (!at_root) begin
          cur_r <= ram_rdata;
        end else if (cur_r != root_a_r) begin
          acc_r <= 1'b1;
        end
      end
      ST_FINISH: begin
        if (out_free) begin
          out_acc_r <= acc_r;
          out_len_r <= max_len_r;
          out_cnt_r <= count_r;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_ch.valid           = out_valid_r;
  assign out_ch.accepted        = out_acc_r;
  assign out_ch.largest_length  = out_len_r;
  assign out_ch.tree_edge_count = out_cnt_r;

  // one edge in flight at a time
  a_one_edge: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("edge taken while walk not started");

  // a link write never makes a node its own parent
  a_no_self_link: assert property (@(posedge clk) disable iff (!rst_n)
    (ram_we && state_r == ST_WALK_B) |-> (ram_waddr != ram_wdata))
    else $error("self link written");

  // a pending result is never overwritten
  a_hold_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> $stable(out_cnt_r) && $stable(out_acc_r))
    else $error("pending result overwritten");

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Testbench for union_find_spanning_tree_builder_top: drives edge words and checks result words
// against an in-bench union-find predictor. Needs uf_mst_pkg, uf_edge_if, uf_result_if and the RTL.
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import uf_mst_pkg::*;

  localparam int TREE_NODES  = 1024;
  localparam int RANDOM_EDGES = 500;

  typedef struct packed {
    logic             accepted;
    logic [LEN_W-1:0] largest_length;
    logic [CNT_W-1:0] tree_edge_count;
  } tree_result_t;

  logic clk = 1'b0;
  logic rst_n;

  uf_edge_if   edge_ch ();
  uf_result_if res_ch ();

  union_find_spanning_tree_builder_top #(.MAX_NODES(TREE_NODES)) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (edge_ch),
    .out_ch (res_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state: parent links, running max length, accepted count
  logic [NODE_ID_W-1:0] parent_of [TREE_NODES];
  logic [LEN_W-1:0]     longest_taken;
  logic [CNT_W-1:0]     edges_taken;
  tree_result_t         expected_results [$];

  int  error_count = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  accepts_seen = 0;
  bit  idle_on = 1'b1;
  int  hold_off_req = 0;
  logic [LEN_W-1:0] cur_len;

  function automatic logic [NODE_ID_W-1:0] root_of_node(input logic [NODE_ID_W-1:0] node);
    logic [NODE_ID_W-1:0] cur;
    logic [NODE_ID_W-1:0] up;
    cur = node;
    for (int s = 0; s < TREE_NODES; s++) begin
      up = parent_of[cur];
      if (up == cur || up >= TREE_NODES) break;
      cur = up;
    end
    return cur;
  endfunction

  function automatic tree_result_t join_edge(input logic [NODE_ID_W-1:0] a, b,
                                             input logic [LEN_W-1:0] len);
    tree_result_t r;
    logic [NODE_ID_W-1:0] ra;
    logic [NODE_ID_W-1:0] rb;
    r.accepted = 1'b0;
    if (a < TREE_NODES && b < TREE_NODES) begin
      ra = root_of_node(a);
      rb = root_of_node(b);
      if (ra != rb) begin
        parent_of[rb] = ra;
        r.accepted = 1'b1;
        if (len > longest_taken) longest_taken = len;
        if (edges_taken < CNT_MAX) edges_taken++;
      end
    end
    r.largest_length  = longest_taken;
    r.tree_edge_count = edges_taken;
    return r;
  endfunction

  // called at a falling edge, returns at a falling edge with valid still high
  task automatic send_edge(input logic [NODE_ID_W-1:0] a, b, input logic [LEN_W-1:0] len);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 8);
      edge_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    edge_ch.valid       <= 1'b1;
    edge_ch.node_a      <= a;
    edge_ch.node_b      <= b;
    edge_ch.edge_length <= len;
    @(posedge clk);
    while (!edge_ch.ready) @(posedge clk);
    expected_results.insert(expected_results.size(), join_edge(a, b, len));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic wait_drained();
    edge_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_results.size() != 0) @(negedge clk);
  endtask

  // first node whose set differs from node 0's, or 0 when the tree is whole
  function automatic logic [NODE_ID_W-1:0] loose_node();
    logic [NODE_ID_W-1:0] r0;
    r0 = root_of_node('0);
    for (int i = 1; i < TREE_NODES; i++)
      if (root_of_node(NODE_ID_W'(i)) != r0) return NODE_ID_W'(i);
    return '0;
  endfunction

  // result side: random stall bursts plus an optional long hold-off
  int hold_left = 0;
  int stall_left = 0;
  initial res_ch.ready = 1'b0;
  always @(negedge clk) begin
    if (hold_off_req != 0) begin
      hold_left = hold_off_req;
      hold_off_req = 0;
    end
    if (hold_left != 0) begin
      hold_left--;
      res_ch.ready <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      res_ch.ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 8) - 1;
      res_ch.ready <= 1'b0;
    end else begin
      res_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin : check_results
    tree_result_t want;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      results_seen++;
      if (res_ch.accepted) accepts_seen++;
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected");
        error_count++;
      end else begin
        want = expected_results.pop_front();
        if (res_ch.accepted !== want.accepted) begin
          $error("accepted: expected %0d, got %0d", want.accepted, res_ch.accepted);
          error_count++;
        end
        if (res_ch.largest_length !== want.largest_length) begin
          $error("largest_length: expected %0d, got %0d",
                 want.largest_length, res_ch.largest_length);
          error_count++;
        end
        if (res_ch.tree_edge_count !== want.tree_edge_count) begin
          $error("tree_edge_count: expected %0d, got %0d",
                 want.tree_edge_count, res_ch.tree_edge_count);
          error_count++;
        end
      end
    end
  end

  // self loop, extreme node ids, zero length, same-set rejection
  task automatic test_basic_edges();
    send_edge(10'd0, 10'd0, 20'd0);
    send_edge(10'd0, 10'd1023, 20'd0);
    send_edge(10'd1023, 10'd0, 20'd0);
    send_edge(10'd1, 10'd2, 20'd1);
    wait_drained();
  endtask

  // a 12-link chain so both root walks go deep
  task automatic test_deep_chain();
    for (int i = 101; i <= 112; i++)
      send_edge(NODE_ID_W'(i), NODE_ID_W'(i - 1), 20'd2);
    send_edge(10'd100, 10'd200, 20'd3);
    send_edge(10'd200, 10'd100, 20'd3);
    cur_len = 20'd3;
    wait_drained();
  endtask

  task automatic test_random_kruskal();
    logic [NODE_ID_W-1:0] a;
    logic [NODE_ID_W-1:0] b;
    logic [LEN_W-1:0]     len;
    int pick;
    for (int n = 0; n < RANDOM_EDGES; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 25) begin
        // small pool: sets merge quickly, many same-set rejects
        a = NODE_ID_W'($urandom_range(0, 63));
        b = NODE_ID_W'($urandom_range(0, 63));
      end else if (pick < 30) begin
        a = NODE_ID_W'($urandom);
        b = a;
      end else begin
        a = NODE_ID_W'($urandom);
        b = NODE_ID_W'($urandom);
      end
      cur_len = cur_len + LEN_W'($urandom_range(0, 900));
      len = cur_len;
      // out-of-order length, no greater than cur_len
      if ($urandom_range(0, 9) == 0) len = LEN_W'($urandom_range(0, cur_len));
      send_edge(a, b, len);
      if (n == 300) begin
        hold_off_req = 400;
        for (int k = 0; k < 30; k++) begin
          cur_len = cur_len + 20'd1;
          send_edge(NODE_ID_W'($urandom), NODE_ID_W'($urandom), cur_len);
        end
      end
      if (n % 200 == 199) wait_drained();
    end
    wait_drained();
  endtask

  // longest length, then a shorter accepted edge that must not lower the max, then a self loop
  task automatic test_length_extremes();
    send_edge(10'd0, loose_node(), 20'hFFFFF);
    send_edge(loose_node(), 10'd0, 20'd5);
    send_edge(10'd0, 10'd0, 20'hFFFFF);
    wait_drained();
  endtask

  // join every remaining set until the count reaches its top, no idling
  task automatic test_complete_tree();
    logic [NODE_ID_W-1:0] r0;
    idle_on = 1'b0;
    for (int i = 1; i < TREE_NODES; i++) begin
      r0 = root_of_node('0);
      if (root_of_node(NODE_ID_W'(i)) != r0)
        send_edge(10'd0, NODE_ID_W'(i), 20'hFFFFF);
    end
    for (int k = 0; k < 20; k++)
      send_edge(NODE_ID_W'($urandom), NODE_ID_W'($urandom), 20'hFFFFF);
    send_edge(10'd1023, 10'd0, 20'hFFFFF);
    wait_drained();
  endtask

  initial begin
    for (int i = 0; i < TREE_NODES; i++) parent_of[i] = NODE_ID_W'(i);
    longest_taken = '0;
    edges_taken   = '0;
    cur_len       = '0;
    rst_n = 1'b0;
    edge_ch.valid       = 1'b0;
    edge_ch.node_a      = '0;
    edge_ch.node_b      = '0;
    edge_ch.edge_length = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_basic_edges();
    test_deep_chain();
    test_random_kruskal();
    test_length_extremes();
    test_complete_tree();

    repeat (40) @(posedge clk);
    $display("Sent %0d edge words, checked %0d result words, %0d edges joined the tree.",
             items_sent, results_seen, accepts_seen);
    $display("Covered self loops, deep chains, unsorted lengths, stalls and a full tree.");
    if (error_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
`default_nettype wire
